[hw/rtl/chm_pkg.sv]
// ----------------------------------------------------------------------------
// chm_pkg
// Shared widths, operation codes and status codes for the chained hash map.
// ----------------------------------------------------------------------------
package chm_pkg;

  // fixed field widths
  localparam int HASH_W  = 32;
  localparam int CFG_W   = 9;
  localparam int COUNT_W = 11;
  localparam int OP_W    = 2;
  localparam int ST_W    = 2;

  // reset bucket count
  localparam logic [CFG_W-1:0] CFG_BUCKETS_RST = 9'd199;

  typedef enum logic [OP_W-1:0] {
    OP_SET = 2'd0,
    OP_GET = 2'd1,
    OP_DEL = 2'd2
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

endpackage

[hw/rtl/chm_mod_unit.sv]
// ----------------------------------------------------------------------------
// chm_mod_unit
// Iterative restoring remainder: hash modulo bucket count, one bit per cycle.
// ----------------------------------------------------------------------------
module chm_mod_unit
  import chm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [HASH_W-1:0] dividend,
  input  logic [CFG_W-1:0]  divisor,
  output logic             done,
  output logic [CFG_W-1:0]  rem
);

  localparam int CNT_W = $clog2(HASH_W);

  logic              busy_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [HASH_W-1:0] quo_r;
  logic [CFG_W-1:0]  dsr_r;
  logic [CFG_W-1:0]  rem_r;
  logic              done_r;
  logic [CFG_W:0]    trial;
  logic [CFG_W:0]    diff;

  // shift in next dividend bit, subtract when it fits
  assign trial = {rem_r, quo_r[HASH_W-1]};
  assign diff  = trial - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        quo_r  <= dividend;
        dsr_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        quo_r <= {quo_r[HASH_W-2:0], 1'b0};
        if (trial >= {1'b0, dsr_r}) begin
          rem_r <= diff[CFG_W-1:0];
        end else begin
          rem_r <= trial[CFG_W-1:0];
        end
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(HASH_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

[hw/rtl/chm_ram.sv]
// ----------------------------------------------------------------------------
// chm_ram
// Simple dual-port memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module chm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/chained_hash_map_core.sv]
// ----------------------------------------------------------------------------
// chained_hash_map_core
// Key-value store with separate chaining over a finite pool of entries.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_* (valid/ready): op, key, key_hash, value. One
//   result per request leaves on out_* (valid/ready): status, read_value and
//   the entry count after the request. cfg_we/cfg_data set the bucket count;
//   write it only while no request is in flight.
//   One request at a time. A request passes through the remainder unit
//   (hash modulo bucket count, one bit per cycle), reads the bucket head,
//   then visits chain entries one at a time through the entry memory read
//   port, ends the walk, updates the chain and posts the result; in_ready
//   returns in the same cycle as the result is posted. An unused op code
//   skips the walk and goes straight to posting the result.
//   After reset the block clears bucket heads and builds the free list, one
//   entry per cycle over max(NUM_BUCKETS, CAPACITY) addresses, with in_ready
//   low. A finished result sits in the output register; while the receiver
//   stalls, the next request is not started past its final step.
// ----------------------------------------------------------------------------
module chained_hash_map_core
  import chm_pkg::*;
#(
  parameter int NUM_BUCKETS = 256,
  parameter int CAPACITY    = 1024,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [OP_W-1:0]        in_op,
  input  logic [KEY_WIDTH-1:0]   in_key,
  input  logic [HASH_W-1:0]      in_key_hash,
  input  logic [VALUE_WIDTH-1:0] in_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [ST_W-1:0]        out_status,
  output logic [VALUE_WIDTH-1:0] out_read_value,
  output logic [COUNT_W-1:0]     out_entry_count,
  input  logic                   cfg_we,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int IDX_W = $clog2(CAPACITY + 1);
  localparam int BW    = $clog2(NUM_BUCKETS);
  localparam int CLR_N = (NUM_BUCKETS > CAPACITY) ? NUM_BUCKETS : CAPACITY;
  localparam int CW    = $clog2(CLR_N);
  localparam logic [IDX_W-1:0] NIL = IDX_W'(CAPACITY);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV, S_HEAD, S_LOAD, S_CHK, S_CMP,
    S_HIT, S_DEL, S_MISS, S_ALLOC, S_FIN
  } state_t;

  state_t                 state_r;
  logic [CW-1:0]          clr_r;
  logic [CFG_W-1:0]       cfg_buckets_r;
  op_t                    op_r;
  logic [KEY_WIDTH-1:0]   key_r;
  logic [HASH_W-1:0]      hash_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [BW-1:0]          bkt_r;
  logic [IDX_W-1:0]       head_r;
  logic [IDX_W-1:0]       cur_r;
  logic [IDX_W-1:0]       prev_r;
  logic [IDX_W-1:0]       hit_next_r;
  logic [IDX_W-1:0]       steps_r;
  logic [IDX_W-1:0]       free_head_r;
  logic [IDX_W-1:0]       count_r;
  status_t                status_r;
  logic [VALUE_WIDTH-1:0] rdv_r;
  logic                   out_valid_r;
  status_t                out_status_r;
  logic [VALUE_WIDTH-1:0] out_rdv_r;
  logic [COUNT_W-1:0]     out_count_r;

  logic                   div_start;
  logic                   div_done;
  logic [CFG_W-1:0]       div_rem;
  logic [CFG_W-1:0]       n_eff;
  logic                   in_xfer;

  logic                   head_we;
  logic [BW-1:0]          head_wa;
  logic [IDX_W-1:0]       head_wd;
  logic [IDX_W-1:0]       head_rd;
  logic                   kh_we;
  logic                   val_we;
  logic [AW-1:0]          val_wa;
  logic                   next_we;
  logic [AW-1:0]          next_wa;
  logic [IDX_W-1:0]       next_wd;
  logic [AW-1:0]          ent_ra;
  logic [KEY_WIDTH-1:0]   key_rd;
  logic [HASH_W-1:0]      hash_rd;
  logic [VALUE_WIDTH-1:0] val_rd;
  logic [IDX_W-1:0]       next_rd;
  logic                   match;
  logic                   cur_nil;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign match    = (hash_rd == hash_r) && (key_rd == key_r);
  assign cur_nil  = (cur_r >= NIL) || (steps_r == NIL);

  // effective bucket count: zero reads as one, clamp to the table size
  always_comb begin
    n_eff = cfg_buckets_r;
    if (cfg_buckets_r == '0) begin
      n_eff = CFG_W'(1);
    end
    if (32'(cfg_buckets_r) > NUM_BUCKETS) begin
      n_eff = CFG_W'(NUM_BUCKETS);
    end
  end

  assign div_start = in_xfer;

  chm_mod_unit u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_key_hash),
    .divisor  (n_eff),
    .done     (div_done),
    .rem      (div_rem)
  );

  // memory write controls per sequencer step
  always_comb begin
    head_we = 1'b0;
    head_wa = bkt_r;
    head_wd = NIL;
    kh_we   = 1'b0;
    val_we  = 1'b0;
    val_wa  = free_head_r[AW-1:0];
    next_we = 1'b0;
    next_wa = free_head_r[AW-1:0];
    next_wd = head_r;
    ent_ra  = cur_r[AW-1:0];
    case (state_r)
      S_CLEAR: begin
        head_we = (32'(clr_r) < NUM_BUCKETS);
        head_wa = BW'(clr_r);
        next_we = (32'(clr_r) < CAPACITY);
        next_wa = AW'(clr_r);
        next_wd = IDX_W'(clr_r) + IDX_W'(1);
      end
      S_HIT: begin
        if (op_r == OP_SET) begin
          val_we = 1'b1;
          val_wa = cur_r[AW-1:0];
        end else if (op_r == OP_DEL) begin
          if (prev_r >= NIL) begin
            head_we = 1'b1;
            head_wd = hit_next_r;
          end else begin
            next_we = 1'b1;
            next_wa = prev_r[AW-1:0];
            next_wd = hit_next_r;
          end
        end
      end
      S_DEL: begin
        next_we = 1'b1;
        next_wa = cur_r[AW-1:0];
        next_wd = free_head_r;
      end
      S_MISS: begin
        ent_ra = free_head_r[AW-1:0];
      end
      S_ALLOC: begin
        kh_we   = 1'b1;
        val_we  = 1'b1;
        next_we = 1'b1;
        head_we = 1'b1;
        head_wd = free_head_r;
      end
      default: begin
      end
    endcase
  end

  chm_ram #(.WIDTH(IDX_W), .DEPTH(NUM_BUCKETS)) u_head (
    .clk(clk), .we(head_we), .waddr(head_wa), .wdata(head_wd),
    .raddr(bkt_r), .rdata(head_rd)
  );

  chm_ram #(.WIDTH(KEY_WIDTH), .DEPTH(CAPACITY)) u_key (
    .clk(clk), .we(kh_we), .waddr(free_head_r[AW-1:0]), .wdata(key_r),
    .raddr(ent_ra), .rdata(key_rd)
  );

  chm_ram #(.WIDTH(HASH_W), .DEPTH(CAPACITY)) u_hash (
    .clk(clk), .we(kh_we), .waddr(free_head_r[AW-1:0]), .wdata(hash_r),
    .raddr(ent_ra), .rdata(hash_rd)
  );

  chm_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_val (
    .clk(clk), .we(val_we), .waddr(val_wa), .wdata(val_r),
    .raddr(ent_ra), .rdata(val_rd)
  );

  chm_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_next (
    .clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
    .raddr(ent_ra), .rdata(next_rd)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_buckets_r <= CFG_BUCKETS_RST;
    end else if (cfg_we) begin
      cfg_buckets_r <= cfg_data;
    end
  end

  // sequencer and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      free_head_r <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // result taken, nothing new posted this cycle
      if (out_valid_r && out_ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + CW'(1);
          if (clr_r == CW'(CLR_N - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            op_r     <= op_t'(in_op);
            key_r    <= in_key;
            hash_r   <= in_key_hash;
            val_r    <= in_value;
            status_r <= ST_OK;
            rdv_r    <= '0;
            if (in_op inside {OP_SET, OP_GET, OP_DEL}) begin
              state_r <= S_DIV;
            end else begin
              state_r <= S_FIN;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            bkt_r   <= BW'(div_rem);
            state_r <= S_HEAD;
          end
        end
        S_HEAD: begin
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          head_r  <= head_rd;
          cur_r   <= head_rd;
          prev_r  <= NIL;
          steps_r <= '0;
          state_r <= S_CHK;
        end
        S_CHK: begin
          if (cur_nil) begin
            state_r <= S_MISS;
          end else begin
            steps_r <= steps_r + IDX_W'(1);
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          if (match) begin
            hit_next_r <= next_rd;
            if (op_r == OP_GET) begin
              rdv_r <= val_rd;
            end
            state_r <= S_HIT;
          end else begin
            prev_r  <= cur_r;
            cur_r   <= next_rd;
            state_r <= S_CHK;
          end
        end
        S_HIT: begin
          if (op_r == OP_DEL) begin
            state_r <= S_DEL;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_DEL: begin
          free_head_r <= cur_r;
          if (count_r != '0) begin
            count_r <= count_r - IDX_W'(1);
          end
          state_r <= S_FIN;
        end
        S_MISS: begin
          if (op_r != OP_SET) begin
            status_r <= ST_NOT_FOUND;
            state_r  <= S_FIN;
          end else if (free_head_r >= NIL) begin
            status_r <= ST_FULL;
            state_r  <= S_FIN;
          end else begin
            state_r <= S_ALLOC;
          end
        end
        S_ALLOC: begin
          free_head_r <= next_rd;
          count_r     <= count_r + IDX_W'(1);
          state_r     <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            out_rdv_r    <= rdv_r;
            out_count_r  <= COUNT_W'(count_r);
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_value  = out_rdv_r;
  assign out_entry_count = out_count_r;

  // entry count never exceeds the pool size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NIL)
    else $error("entry count above capacity");

  // chain walk step counter stays within the pool size
  a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK || state_r == S_CMP) |-> steps_r <= NIL)
    else $error("chain walk overran bound");

  // a result other than found carries a zero value
  a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> out_rdv_r == '0)
    else $error("value on failed request");

  // one request at a time: ready drops after an accepted transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready)
    else $error("request accepted while busy");

endmodule
